// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the proposer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pp_pkg.sv =====
// Types, codes and constants of the Paxos proposer.
// No dependencies; used by the response channel interface and all proposer modules.
`default_nettype none

package pp_pkg;

   localparam int MAX_PEERS  = 16;
   localparam int PEERS      = 16;
   localparam int PEER_LIMIT = (MAX_PEERS < PEERS) ? MAX_PEERS : PEERS;
   localparam int IDX_W      = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_NEW    = 2'd0;
   localparam logic [1:0] OP_MSG    = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_COMMIT = 2'd3;

   localparam logic [2:0] MT_P1_ACK  = 3'd0;
   localparam logic [2:0] MT_P1_NACK = 3'd1;
   localparam logic [2:0] MT_P2_ACK  = 3'd2;
   localparam logic [2:0] MT_P2_NACK = 3'd3;
   localparam logic [2:0] MT_COMMIT  = 3'd4;

   localparam logic [1:0] DEST_ACCEPTOR = 2'd0;
   localparam logic [1:0] DEST_SENDER   = 2'd1;
   localparam logic [1:0] DEST_STATUS   = 2'd2;

   localparam logic [1:0] OUT_P1     = 2'd0;
   localparam logic [1:0] OUT_P2     = 2'd1;
   localparam logic [1:0] OUT_COMMIT = 2'd2;
   localparam logic [1:0] OUT_NONE   = 2'd3;

   localparam logic [1:0] ST_IGNORED = 2'd0;
   localparam logic [1:0] ST_HANDLED = 2'd1;
   localparam logic [1:0] ST_SELF    = 2'd2;
   localparam logic [1:0] ST_OTHER   = 2'd3;

   localparam logic [1:0] PH_INIT = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_TWO  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam logic [2:0] REG_GROUP_ID       = 3'd0;
   localparam logic [2:0] REG_VOTING_VERSION = 3'd1;
   localparam logic [2:0] REG_ACCEPTOR_COUNT = 3'd2;
   localparam logic [2:0] REG_CONNECT_MASK   = 3'd3;
   localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;

   typedef struct packed {
      logic [15:0] group_id;
      logic [31:0] voting_version;
      logic [4:0]  acceptor_count;
      logic [15:0] connect_mask;
      logic [31:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic [15:0] mask;
   } mask_load_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  msg_type;
      logic [31:0] msg_version;
      logic [15:0] msg_group;
      logic [15:0] proposal_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]       dest;
      logic [IDX_W-1:0] acceptor_index;
      logic [1:0]       out_type;
      logic [31:0]      out_version;
      logic [15:0]      out_proposal;
      logic [1:0]       status;
      logic             ready_to_commit;
      logic [15:0]      committing_proposal;
      logic [1:0]       phase_now;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pp_req_if.sv =====
// Request channel of the Paxos proposer: valid/ready handshake and payload.
// Has no dependencies.
`default_nettype none

interface pp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  msg_type;
   logic [31:0] msg_version;
   logic [15:0] msg_group;
   logic [15:0] proposal_handle;

   modport source (output valid, opcode, msg_type, msg_version, msg_group, proposal_handle,
                   input ready);
   modport sink (input valid, opcode, msg_type, msg_version, msg_group, proposal_handle,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pp_rsp_if.sv =====
// Response channel of the Paxos proposer: valid/ready handshake and payload.
// Depends on pp_pkg for the acceptor index width.
`default_nettype none

interface pp_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               dest;
   logic [pp_pkg::IDX_W-1:0] acceptor_index;
   logic [1:0]               out_type;
   logic [31:0]              out_version;
   logic [15:0]              out_proposal;
   logic [1:0]               status;
   logic                     ready_to_commit;
   logic [15:0]              committing_proposal;
   logic [1:0]               phase_now;
   logic                     last;

   modport source (output valid, dest, acceptor_index, out_type, out_version, out_proposal,
                   status, ready_to_commit, committing_proposal, phase_now, last,
                   input ready);
   modport sink (input valid, dest, acceptor_index, out_type, out_version, out_proposal,
                 status, ready_to_commit, committing_proposal, phase_now, last,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/paxos_proposer.sv =====
// Proposer side of a three-phase Paxos round with a sequenced broadcast.
// The status response follows acceptance, a reply to the sender or a broadcast, which
// visits the sixteen acceptor slots one per cycle unless a blocked response holds it.
// A new request is taken only once the status response is issued; a blocked response stalls the sequencer.
// Synchronous active-high reset clears the round, counters, masks and configuration.
// Depends on pp_pkg, pp_req_if, pp_rsp_if, pp_csr and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module paxos_proposer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pp_req_if.sink                             req,
   pp_rsp_if.source                           rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [pp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_REPLY  = 5'b01000,
      S_STATUS = 5'b10000
   } state_type;

   pp_pkg::cfg_type       cfg;
   pp_pkg::mask_load_type mask_load;

   state_type state_ff, state_in;
   pp_pkg::req_type req_ff;
   pp_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  p1a_ff, p1a_in, p1n_ff, p1n_in, p2a_ff, p2a_in, p2n_ff, p2n_in;
   logic [31:0] age_ff, age_in;
   logic [15:0] live_ff, live_in, cur_ff, cur_in, com_ff, com_in;

   logic [pp_pkg::PEERS-1:0] scan_mask_ff;
   logic [pp_pkg::IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic [1:0]  btype_ff, btype_in, st_ff, st_in;
   logic [15:0] bprop_ff, bprop_in;
   logic        bcast, reply;

   logic [pp_pkg::PEERS-1:0] lim_mask;
   logic [31:0] age_inc, cmp_a, cmp_b;
   logic        a_lt, a_gt, slot_free, ready_now;
   logic [7:0]  p1a_inc, p1n_inc, p2a_inc, p2n_inc;

   logic        req_fire, rsp_last, rsp_is_status, msg_held;

   pp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg       (cfg),
      .mask_load (mask_load)
   );

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic majority(input logic [7:0] acks, input logic [4:0] count);
      majority = ({acks, 1'b0} > {4'd0, count}) || (count == 5'd0);
   endfunction

   assign req.ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign ready_now = (phase_ff == pp_pkg::PH_TWO) && majority(p2a_ff, cfg.acceptor_count);

   always_comb begin
      for (int i = 0; i < pp_pkg::PEERS; i++) begin
         lim_mask[i] = (6'(i) < {1'b0, cfg.acceptor_count}) && (i < pp_pkg::PEER_LIMIT);
      end
   end

   // One magnitude comparator serves the version check and the timeout check.
   assign age_inc = (age_ff == 32'hFFFF_FFFF) ? age_ff : age_ff + 32'd1;
   assign cmp_a   = (req_ff.opcode == pp_pkg::OP_TICK) ? age_inc : cfg.voting_version;
   assign cmp_b   = (req_ff.opcode == pp_pkg::OP_TICK) ? cfg.timeout_ticks : req_ff.msg_version;
   assign a_lt    = cmp_a < cmp_b;
   assign a_gt    = cmp_a > cmp_b;

   assign p1a_inc = sat_inc(p1a_ff);
   assign p1n_inc = sat_inc(p1n_ff);
   assign p2a_inc = sat_inc(p2a_ff);
   assign p2n_inc = sat_inc(p2n_ff);

   always_comb begin
      phase_in = phase_ff;
      p1a_in   = p1a_ff;
      p1n_in   = p1n_ff;
      p2a_in   = p2a_ff;
      p2n_in   = p2n_ff;
      age_in   = age_ff;
      live_in  = live_ff;
      cur_in   = cur_ff;
      com_in   = com_ff;
      bcast    = 1'b0;
      reply    = 1'b0;
      btype_in = pp_pkg::OUT_P1;
      bprop_in = cur_ff;
      st_in    = pp_pkg::ST_IGNORED;
      unique case (req_ff.opcode)
         pp_pkg::OP_NEW: begin
            cur_in   = req_ff.proposal_handle;
            p1a_in   = '0;
            p1n_in   = '0;
            p2a_in   = '0;
            p2n_in   = '0;
            bcast    = 1'b1;
            bprop_in = req_ff.proposal_handle;
            age_in   = '0;
            if (cfg.acceptor_count != 5'd0) begin
               phase_in = pp_pkg::PH_ONE;
               st_in    = pp_pkg::ST_HANDLED;
            end else begin
               phase_in = pp_pkg::PH_TWO;
               st_in    = pp_pkg::ST_SELF;
            end
         end
         pp_pkg::OP_MSG: begin
            if (req_ff.msg_group != cfg.group_id) begin
               st_in = pp_pkg::ST_IGNORED;
            end else if (a_lt) begin
               st_in = pp_pkg::ST_HANDLED;
            end else if (a_gt) begin
               reply = 1'b1;
               st_in = pp_pkg::ST_HANDLED;
            end else begin
               case (req_ff.msg_type) inside
                  pp_pkg::MT_P1_ACK, pp_pkg::MT_P1_NACK: begin
                     st_in = pp_pkg::ST_HANDLED;
                     reply = (phase_ff == pp_pkg::PH_DONE);
                     if (phase_ff == pp_pkg::PH_ONE) begin
                        if (req_ff.msg_type == pp_pkg::MT_P1_ACK) begin
                           p1a_in = p1a_inc;
                        end else begin
                           p1n_in = p1n_inc;
                        end
                        if (majority(p1a_in, cfg.acceptor_count)) begin
                           bcast    = 1'b1;
                           btype_in = pp_pkg::OUT_P2;
                           phase_in = pp_pkg::PH_TWO;
                           p2a_in   = '0;
                           p2n_in   = '0;
                           age_in   = '0;
                        end
                     end
                  end
                  pp_pkg::MT_P2_ACK, pp_pkg::MT_P2_NACK: begin
                     st_in = pp_pkg::ST_HANDLED;
                     reply = (phase_ff == pp_pkg::PH_DONE);
                     if (phase_ff == pp_pkg::PH_TWO) begin
                        if (req_ff.msg_type == pp_pkg::MT_P2_ACK) begin
                           p2a_in = p2a_inc;
                        end else begin
                           p2n_in = p2n_inc;
                        end
                        if (majority(p2a_in, cfg.acceptor_count)) begin
                           st_in = pp_pkg::ST_SELF;
                        end
                     end
                  end
                  pp_pkg::MT_COMMIT: begin
                     st_in = pp_pkg::ST_HANDLED;
                     if (phase_ff != pp_pkg::PH_DONE) begin
                        live_in  = '0;
                        phase_in = pp_pkg::PH_DONE;
                        age_in   = '0;
                        com_in   = req_ff.proposal_handle;
                        st_in    = pp_pkg::ST_OTHER;
                     end
                  end
                  default: st_in = pp_pkg::ST_IGNORED;
               endcase
            end
         end
         pp_pkg::OP_TICK: begin
            age_in = age_inc;
            if (a_gt && (phase_ff == pp_pkg::PH_ONE || phase_ff == pp_pkg::PH_TWO)) begin
               p1a_in   = '0;
               p1n_in   = '0;
               p2a_in   = '0;
               p2n_in   = '0;
               phase_in = pp_pkg::PH_INIT;
               age_in   = '0;
               st_in    = pp_pkg::ST_HANDLED;
            end
         end
         pp_pkg::OP_COMMIT: begin
            if (ready_now) begin
               cur_in   = '0;
               bcast    = 1'b1;
               btype_in = pp_pkg::OUT_COMMIT;
               bprop_in = cur_ff;
               live_in  = '0;
               phase_in = pp_pkg::PH_DONE;
               age_in   = '0;
               com_in   = cur_ff;
               st_in    = pp_pkg::ST_HANDLED;
            end
         end
         default: st_in = pp_pkg::ST_IGNORED;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            scan_idx_in = '0;
            if (reply) begin
               state_in = S_REPLY;
            end else if (bcast) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_SCAN: begin
            if (!scan_mask_ff[scan_idx_ff] || slot_free) begin
               scan_idx_in = scan_idx_ff + pp_pkg::IDX_W'(1);
               if (scan_idx_ff == pp_pkg::IDX_W'(pp_pkg::PEERS - 1)) begin
                  state_in = S_STATUS;
               end
               if (scan_mask_ff[scan_idx_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
                  rsp_in.dest           = pp_pkg::DEST_ACCEPTOR;
                  rsp_in.acceptor_index = scan_idx_ff;
                  rsp_in.out_type       = btype_ff;
                  rsp_in.out_version    = cfg.voting_version;
                  rsp_in.out_proposal   = bprop_ff;
               end
            end
         end
         S_REPLY: begin
            if (slot_free) begin
               state_in     = S_STATUS;
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.dest         = pp_pkg::DEST_SENDER;
               rsp_in.out_type     = pp_pkg::OUT_COMMIT;
               rsp_in.out_version  = req_ff.msg_version;
               rsp_in.out_proposal = com_ff;
            end
         end
         S_STATUS: begin
            if (slot_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.dest            = pp_pkg::DEST_STATUS;
               rsp_in.out_type        = pp_pkg::OUT_NONE;
               rsp_in.status          = st_ff;
               rsp_in.ready_to_commit = ready_now;
               rsp_in.committing_proposal = ready_now ? cur_ff :
                  ((phase_ff == pp_pkg::PH_DONE) ? com_ff : 16'd0);
               rsp_in.phase_now       = phase_ff;
               rsp_in.last            = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= pp_pkg::PH_INIT;
         p1a_ff       <= '0;
         p1n_ff       <= '0;
         p2a_ff       <= '0;
         p2n_ff       <= '0;
         age_ff       <= '0;
         live_ff      <= '0;
         cur_ff       <= '0;
         com_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXEC) begin
            phase_ff <= phase_in;
            p1a_ff   <= p1a_in;
            p1n_ff   <= p1n_in;
            p2a_ff   <= p2a_in;
            p2n_ff   <= p2n_in;
            age_ff   <= age_in;
            live_ff  <= live_in;
            cur_ff   <= cur_in;
            com_ff   <= com_in;
         end else if (mask_load.load) begin
            live_ff <= mask_load.mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      scan_idx_ff <= scan_idx_in;
      if (req.valid && req.ready) begin
         req_ff.opcode          <= req.opcode;
         req_ff.msg_type        <= req.msg_type;
         req_ff.msg_version     <= req.msg_version;
         req_ff.msg_group       <= req.msg_group;
         req_ff.proposal_handle <= req.proposal_handle;
      end
      if (state_ff == S_EXEC) begin
         scan_mask_ff <= live_ff & lim_mask;
         btype_ff     <= btype_in;
         bprop_ff     <= bprop_in;
         st_ff        <= st_in;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.dest                = rsp_ff.dest;
   assign rsp.acceptor_index      = rsp_ff.acceptor_index;
   assign rsp.out_type            = rsp_ff.out_type;
   assign rsp.out_version         = rsp_ff.out_version;
   assign rsp.out_proposal        = rsp_ff.out_proposal;
   assign rsp.status              = rsp_ff.status;
   assign rsp.ready_to_commit     = rsp_ff.ready_to_commit;
   assign rsp.committing_proposal = rsp_ff.committing_proposal;
   assign rsp.phase_now           = rsp_ff.phase_now;
   assign rsp.last                = rsp_ff.last;

   assign req_fire      = req.valid && req.ready;
   assign rsp_last      = rsp_valid_ff && rsp_ff.last;
   assign rsp_is_status = (rsp_ff.dest == pp_pkg::DEST_STATUS) &&
                          (rsp_ff.out_type == pp_pkg::OUT_NONE);
   assign msg_held      = rsp_valid_ff && !rsp_ff.last;

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req.ready, "ready after a request")
   `ASSERT_IMPLY(a_last_is_status, clock, reset, rsp_last, rsp_is_status, "bad final item")
   `ASSERT_IMPLY(a_idle_only_status_pending, clock, reset, req.ready, !msg_held, "stray message")

endmodule

`default_nettype wire

// ===== hw/rtl/pp_csr.sv =====
// APB-style configuration registers of the Paxos proposer.
// Depends on pp_pkg for the register indexes and the configuration struct.
`default_nettype none

module pp_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [pp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [pp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output pp_pkg::cfg_type                    cfg,
   output pp_pkg::mask_load_type              mask_load
);

   pp_pkg::cfg_type cfg_ff;
   pp_pkg::cfg_type cfg_in;
   logic            wr_en;
   logic [2:0]      index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            pp_pkg::REG_GROUP_ID:       cfg_in.group_id       = pwdata[15:0];
            pp_pkg::REG_VOTING_VERSION: cfg_in.voting_version = pwdata[31:0];
            pp_pkg::REG_ACCEPTOR_COUNT: cfg_in.acceptor_count = pwdata[4:0];
            pp_pkg::REG_CONNECT_MASK:   cfg_in.connect_mask   = pwdata[15:0];
            pp_pkg::REG_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = pwdata[31:0];
            default:                    cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         pp_pkg::REG_GROUP_ID:       prdata = {16'd0, cfg_ff.group_id};
         pp_pkg::REG_VOTING_VERSION: prdata = cfg_ff.voting_version;
         pp_pkg::REG_ACCEPTOR_COUNT: prdata = {27'd0, cfg_ff.acceptor_count};
         pp_pkg::REG_CONNECT_MASK:   prdata = {16'd0, cfg_ff.connect_mask};
         pp_pkg::REG_TIMEOUT_TICKS:  prdata = cfg_ff.timeout_ticks;
         default:                    prdata = '0;
      endcase
   end

   assign cfg            = cfg_ff;
   assign mask_load.load = wr_en && (index == pp_pkg::REG_CONNECT_MASK);
   assign mask_load.mask = pwdata[15:0];

endmodule

`default_nettype wire

// ===== tb/pp_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the Paxos proposer: watches the request, response and CSR ports,
// predicts every response from its own copy of the round state and compares in order.
// Depends on pp_pkg, pp_req_if and pp_rsp_if.

module pp_checker
   import pp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   pp_req_if                          req,
   pp_rsp_if                          rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   output int                         pending,
   output int                         fail_count
);

   logic [15:0] grp_id;
   logic [31:0] vote_ver;
   logic [4:0]  n_acceptors;
   logic [15:0] conn_mask;
   logic [31:0] tmo_ticks;

   logic [1:0]  ph;
   logic [7:0]  p1_ack_cnt, p1_nack_cnt, p2_ack_cnt, p2_nack_cnt;
   logic [31:0] age;
   logic [15:0] live;
   logic [15:0] cur_prop;
   logic [15:0] done_prop;

   rsp_type due_msgs[$];
   int      reports;

   initial begin
      pending    = 0;
      fail_count = 0;
      reports    = 0;
   end

   function automatic void push_msg(input logic [1:0] dest, input logic [IDX_W-1:0] idx,
                                     input logic [1:0] kind, input logic [31:0] ver,
                                     input logic [15:0] prop);
      rsp_type m;
      m                = '0;
      m.dest           = dest;
      m.acceptor_index = idx;
      m.out_type       = kind;
      m.out_version    = ver;
      m.out_proposal   = prop;
      due_msgs.push_back(m);
   endfunction

   function automatic void fan_out(input logic [1:0] kind, input logic [15:0] prop);
      int reach;
      reach = int'(n_acceptors);
      if (reach > 16) reach = 16;
      if (reach > PEER_LIMIT) reach = PEER_LIMIT;
      for (int i = 0; i < reach; i++)
         if (live[i]) push_msg(DEST_ACCEPTOR, IDX_W'(i), kind, vote_ver, prop);
   endfunction

   function automatic logic [7:0] bump(input logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
   endfunction

   function automatic logic can_commit();
      return ph == PH_TWO && (int'(p2_ack_cnt) * 2 > int'(n_acceptors) || n_acceptors == 0);
   endfunction

   function automatic void clear_round();
      p1_ack_cnt  = '0;
      p1_nack_cnt = '0;
      p2_ack_cnt  = '0;
      p2_nack_cnt = '0;
      age         = '0;
   endfunction

   function automatic void seal(input logic [15:0] prop);
      live      = '0;
      ph        = PH_DONE;
      age       = '0;
      done_prop = prop;
   endfunction

   function automatic void reset_round();
      grp_id      = '0;
      vote_ver    = '0;
      n_acceptors = '0;
      conn_mask   = '0;
      tmo_ticks   = '0;
      clear_round();
      ph          = PH_INIT;
      live        = '0;
      cur_prop    = '0;
      done_prop   = '0;
   endfunction

   function automatic void write_reg(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_GROUP_ID:       grp_id = value[15:0];
         REG_VOTING_VERSION: vote_ver = value;
         REG_ACCEPTOR_COUNT: n_acceptors = value[4:0];
         REG_CONNECT_MASK: begin
            conn_mask = value[15:0];
            live      = value[15:0];
         end
         REG_TIMEOUT_TICKS:  tmo_ticks = value;
         default: ;
      endcase
   endfunction

   function automatic logic [1:0] take_message(input req_type r);
      if (r.msg_group != grp_id) return ST_IGNORED;
      if (vote_ver < r.msg_version) return ST_HANDLED;
      if (vote_ver > r.msg_version) begin
         push_msg(DEST_SENDER, '0, OUT_COMMIT, r.msg_version, done_prop);
         return ST_HANDLED;
      end
      case (r.msg_type)
         MT_P1_ACK, MT_P1_NACK: begin
            if (ph == PH_DONE) push_msg(DEST_SENDER, '0, OUT_COMMIT, vote_ver, done_prop);
            if (ph != PH_ONE) return ST_HANDLED;
            if (r.msg_type == MT_P1_ACK) p1_ack_cnt = bump(p1_ack_cnt);
            else p1_nack_cnt = bump(p1_nack_cnt);
            if (int'(p1_ack_cnt) * 2 > int'(n_acceptors) || n_acceptors == 0) begin
               fan_out(OUT_P2, cur_prop);
               ph          = PH_TWO;
               p2_ack_cnt  = '0;
               p2_nack_cnt = '0;
               age         = '0;
            end
            return ST_HANDLED;
         end
         MT_P2_ACK, MT_P2_NACK: begin
            if (ph == PH_DONE) begin
               push_msg(DEST_SENDER, '0, OUT_COMMIT, vote_ver, done_prop);
               return ST_HANDLED;
            end
            if (ph != PH_TWO) return ST_HANDLED;
            if (r.msg_type == MT_P2_ACK) p2_ack_cnt = bump(p2_ack_cnt);
            else p2_nack_cnt = bump(p2_nack_cnt);
            return can_commit() ? ST_SELF : ST_HANDLED;
         end
         MT_COMMIT: begin
            if (ph == PH_DONE) return ST_HANDLED;
            seal(r.proposal_handle);
            return ST_OTHER;
         end
         default: return ST_IGNORED;
      endcase
   endfunction

   function automatic void predict_request(input req_type r);
      logic [1:0]  st;
      logic [15:0] prop;
      rsp_type     s;
      st = ST_IGNORED;
      case (r.opcode)
         OP_NEW: begin
            cur_prop = r.proposal_handle;
            clear_round();
            fan_out(OUT_P1, cur_prop);
            if (n_acceptors != 0) begin
               ph = PH_ONE;
               st = ST_HANDLED;
            end else begin
               ph = PH_TWO;
               st = ST_SELF;
            end
         end
         OP_MSG: st = take_message(r);
         OP_TICK: begin
            if (age != 32'hFFFF_FFFF) age = age + 32'd1;
            if (age > tmo_ticks && (ph == PH_ONE || ph == PH_TWO)) begin
               clear_round();
               ph = PH_INIT;
               st = ST_HANDLED;
            end
         end
         OP_COMMIT: begin
            if (can_commit()) begin
               prop     = cur_prop;
               cur_prop = '0;
               fan_out(OUT_COMMIT, prop);
               seal(prop);
               st = ST_HANDLED;
            end
         end
         default: ;
      endcase
      s                     = '0;
      s.dest                = DEST_STATUS;
      s.out_type            = OUT_NONE;
      s.status              = st;
      s.ready_to_commit     = can_commit();
      s.committing_proposal = can_commit() ? cur_prop : (ph == PH_DONE ? done_prop : 16'd0);
      s.phase_now           = ph;
      s.last                = 1'b1;
      due_msgs.push_back(s);
   endfunction

   function automatic string show(input rsp_type m);
      return $sformatf("dest=%0d idx=%0d type=%0d ver=%h prop=%h st=%0d rdy=%0b cp=%h ph=%0d last=%0b",
                       m.dest, m.acceptor_index, m.out_type, m.out_version, m.out_proposal,
                       m.status, m.ready_to_commit, m.committing_proposal, m.phase_now, m.last);
   endfunction

   always @(posedge clock) begin
      req_type r;
      rsp_type got, want;
      if (reset) begin
         reset_round();
         due_msgs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_reg(csr_paddr[4:2], csr_pwdata);
         if (req.valid && req.ready) begin
            r.opcode          = req.opcode;
            r.msg_type        = req.msg_type;
            r.msg_version     = req.msg_version;
            r.msg_group       = req.msg_group;
            r.proposal_handle = req.proposal_handle;
            predict_request(r);
         end
         if (rsp.valid && rsp.ready) begin
            got.dest                = rsp.dest;
            got.acceptor_index      = rsp.acceptor_index;
            got.out_type            = rsp.out_type;
            got.out_version         = rsp.out_version;
            got.out_proposal        = rsp.out_proposal;
            got.status              = rsp.status;
            got.ready_to_commit     = rsp.ready_to_commit;
            got.committing_proposal = rsp.committing_proposal;
            got.phase_now           = rsp.phase_now;
            got.last                = rsp.last;
            if (due_msgs.size() == 0) begin
               fail_count = fail_count + 1;
               if (reports < 10) begin
                  reports = reports + 1;
                  $display("%0t: unexpected response %s", $realtime, show(got));
               end
            end else begin
               want = due_msgs.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  if (reports < 10) begin
                     reports = reports + 1;
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(got));
                  end
               end
            end
         end
      end
      pending = due_msgs.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the Paxos proposer testbench: clock, reset, CSR setup, directed and random requests.
// Depends on pp_pkg, pp_req_if, pp_rsp_if, paxos_proposer and pp_checker.

module tb;
   import pp_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_GOAL = 450;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          pending;
   int          fail_count;
   bit          req_gaps   = 1'b0;
   bit          rsp_gaps   = 1'b0;
   bit          rsp_fire   = 1'b0;
   int unsigned rsp_stall  = 0;
   int unsigned quiet      = 0;
   int          useful     = 0;
   int          phase_end;

   logic [15:0] cfg_group   = '0;
   logic [31:0] cfg_version = '0;
   logic [4:0]  cfg_count   = '0;

   pp_req_if req_ch();
   pp_rsp_if rsp_ch();

   paxos_proposer dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pp_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_fire <= rsp_ch.valid && rsp_ch.ready;

   always @(negedge clock) begin
      if (rsp_fire && rsp_gaps) rsp_stall = $urandom_range(0, 13);
      if (rsp_stall != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet == QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_type pack_request(input logic [1:0] op, input logic [2:0] mt,
                                            input logic [31:0] ver, input logic [15:0] grp,
                                            input logic [15:0] hnd);
      req_type r;
      r.opcode          = op;
      r.msg_type        = mt;
      r.msg_version     = ver;
      r.msg_group       = grp;
      r.proposal_handle = hnd;
      return r;
   endfunction

   function automatic req_type vote(input logic [2:0] mt);
      return pack_request(OP_MSG, mt, cfg_version, cfg_group, 16'($urandom));
   endfunction

   function automatic req_type plain_op(input logic [1:0] op, input logic [15:0] hnd);
      return pack_request(op, 3'($urandom), $urandom, 16'($urandom), hnd);
   endfunction

   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = req_gaps ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.opcode          <= r.opcode;
      req_ch.msg_type        <= r.msg_type;
      req_ch.msg_version     <= r.msg_version;
      req_ch.msg_group       <= r.msg_group;
      req_ch.proposal_handle <= r.proposal_handle;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] g, input logic [31:0] v, input logic [4:0] n,
                             input logic [15:0] m, input logic [31:0] t);
      stop_requests();
      wait_drained();
      csr_write(REG_GROUP_ID, {16'd0, g});
      csr_write(REG_VOTING_VERSION, v);
      csr_write(REG_ACCEPTOR_COUNT, {27'd0, n});
      csr_write(REG_CONNECT_MASK, {16'd0, m});
      csr_write(REG_TIMEOUT_TICKS, t);
      cfg_group   = g;
      cfg_version = v;
      cfg_count   = n;
   endtask

   task automatic random_config();
      logic [15:0] g, m;
      logic [31:0] v, t;
      logic [4:0]  n;
      case ($urandom_range(0, 3))
         0:       g = 16'h0000;
         1:       g = 16'hFFFF;
         default: g = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       v = 32'h0000_0000;
         1:       v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       n = 5'd0;
         1:       n = 5'd1;
         2:       n = 5'd16;
         default: n = 5'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 4))
         0:       m = 16'h0000;
         1:       m = 16'hFFFF;
         default: m = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       t = 32'd0;
         1:       t = 32'hFFFF_FFFF;
         2:       t = $urandom;
         default: t = $urandom_range(1, 12);
      endcase
      set_config(g, v, n, m, t);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 6))
         0: send_request(pack_request(OP_MSG, 3'($urandom_range(0, 7)), cfg_version,
                                      cfg_group ^ 16'($urandom_range(1, 16'hFFFF)),
                                      16'($urandom)));
         1: begin
            send_request(pack_request(OP_MSG, 3'($urandom_range(0, 4)), $urandom,
                                      cfg_group, 16'($urandom)));
            useful++;
         end
         2: begin
            send_request(pack_request(OP_MSG, 3'($urandom_range(0, 4)),
                                      $urandom_range(0, 1) ? cfg_version + 32'd1
                                                           : cfg_version - 32'd1,
                                      cfg_group, 16'($urandom)));
            useful++;
         end
         3: send_request(pack_request(OP_MSG, 3'($urandom_range(5, 7)), cfg_version,
                                      cfg_group, 16'($urandom)));
         4: begin
            send_request(plain_op(OP_TICK, 16'($urandom)));
            useful++;
         end
         5: begin
            send_request(vote(MT_COMMIT));
            useful++;
         end
         default: begin
            send_request(pack_request(2'($urandom), 3'($urandom), $urandom, 16'($urandom),
                                      16'($urandom)));
            useful++;
         end
      endcase
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 5) == 0) send_noise();
   endtask

   task automatic play_round();
      int unsigned votes;
      logic [15:0] h;
      case ($urandom_range(0, 7))
         0:       h = 16'h0000;
         1:       h = 16'hFFFF;
         default: h = 16'($urandom);
      endcase
      send_request(plain_op(OP_NEW, h));
      useful++;
      votes = cfg_count / 2 + 1 + $urandom_range(0, 1);
      repeat (votes) begin
         maybe_noise();
         send_request(vote(($urandom_range(0, 3) != 0) ? MT_P1_ACK : MT_P1_NACK));
         useful++;
      end
      repeat (votes) begin
         maybe_noise();
         send_request(vote(($urandom_range(0, 3) != 0) ? MT_P2_ACK : MT_P2_NACK));
         useful++;
      end
      if ($urandom_range(0, 4) != 0) begin
         send_request(plain_op(OP_COMMIT, 16'($urandom)));
         useful++;
      end
      maybe_noise();
   endtask

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.opcode          = OP_NEW;
      req_ch.msg_type        = MT_P1_ACK;
      req_ch.msg_version     = '0;
      req_ch.msg_group       = '0;
      req_ch.proposal_handle = '0;
      rsp_ch.ready           = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: no acceptors, so a proposal is ready to commit at once.
      send_request(plain_op(OP_TICK, 16'h0000));
      send_request(plain_op(OP_NEW, 16'h0001));
      send_request(plain_op(OP_COMMIT, 16'hFFFF));

      set_config(16'hFFFF, 32'hFFFF_FFFF, 5'd16, 16'hFFFF, 32'd0);
      send_request(plain_op(OP_NEW, 16'hFFFF));
      send_request(pack_request(OP_MSG, MT_P1_ACK, 32'hFFFF_FFFF, 16'h0000, 16'h0000));
      send_request(pack_request(OP_MSG, MT_P1_ACK, 32'h0000_0000, 16'hFFFF, 16'h0000));
      send_request(pack_request(OP_MSG, 3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
      send_request(pack_request(OP_MSG, 3'd5, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000));
      send_request(vote(MT_P2_NACK));
      send_request(plain_op(OP_TICK, 16'h0000));
      send_request(plain_op(OP_TICK, 16'hFFFF));
      send_request(pack_request(OP_MSG, MT_COMMIT, 32'hFFFF_FFFF, 16'hFFFF, 16'hABCD));
      send_request(vote(MT_P1_NACK));
      send_request(vote(MT_P2_ACK));
      send_request(vote(MT_COMMIT));
      send_request(plain_op(OP_NEW, 16'h5555));

      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      set_config(16'h0000, 32'h0000_0000, 5'd1, 16'h0001, 32'hFFFF_FFFF);
      send_request(plain_op(OP_NEW, 16'h0000));
      send_request(pack_request(OP_MSG, MT_P1_ACK, 32'd1, 16'h0000, 16'h0000));
      send_request(vote(MT_P1_ACK));
      send_request(plain_op(OP_COMMIT, 16'h0000));
      send_request(vote(MT_P2_NACK));
      send_request(vote(MT_P2_ACK));
      send_request(plain_op(OP_COMMIT, 16'h0000));
      send_request(plain_op(OP_COMMIT, 16'h0000));
      send_request(plain_op(OP_TICK, 16'h0000));

      while (useful < RANDOM_GOAL) begin
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         random_config();
         phase_end = useful + $urandom_range(20, 45);
         while (useful < phase_end) begin
            play_round();
            if ($urandom_range(0, 4) == 0) begin
               stop_requests();
               wait_drained();
            end
         end
      end

      stop_requests();
      wait_drained();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
